// ===== hw/rtl/src_pkg.sv =====
package src_pkg;

    // Width of the generation counter and of a running job's tag.
    localparam int GEN_BITS = 16;

    localparam int CMD_BITS  = 3;
    localparam int MODE_BITS = 2;
    localparam int TAG_BITS  = 16;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACTIVATE    = 3'd0,
        CMD_REQUEST     = 3'd1,
        CMD_PAUSE       = 3'd2,
        CMD_STOP        = 3'd3,
        CMD_TAKE_BASE   = 3'd4,
        CMD_TAKE_NEXT   = 3'd5,
        CMD_FINISH      = 3'd6
    } cmd_t;

    localparam logic [MODE_BITS-1:0] MODE_FAST          = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SLOW          = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FAST_AND_SLOW = 2'd2;

    typedef logic [GEN_BITS-1:0] gen_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [MODE_BITS-1:0] mode;
        logic [TAG_BITS-1:0]  item_generation;
    } src_req_t;

    typedef struct packed {
        logic                 ok;
        logic                 granted_valid;
        logic [MODE_BITS-1:0] granted_mode;
        logic [TAG_BITS-1:0]  granted_generation;
        logic                 has_action;
        logic                 busy_res;
        logic                 is_stopped;
    } src_rsp_t;

    // Does a job of mode have cover a request for mode want.
    function automatic logic mode_covers(logic [MODE_BITS-1:0] have,
                                         logic [MODE_BITS-1:0] want);
        return (have == MODE_FAST_AND_SLOW) || (have == want);
    endfunction

endpackage

// ===== hw/rtl/src_core.sv =====
module src_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  src_pkg::src_req_t req,
    output src_pkg::src_rsp_t rsp
);
    import src_pkg::*;

    logic                 stopped_reg,  stopped_next;
    logic                 accepting_reg, accepting_next;
    logic                 base_pend_reg, base_pend_next;
    logic                 run_vld_reg,  run_vld_next;
    logic [MODE_BITS-1:0] run_mode_reg, run_mode_next;
    gen_t                 run_gen_reg,  run_gen_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [MODE_BITS-1:0] pend_mode_reg, pend_mode_next;
    gen_t                 gen_cnt_reg,  gen_cnt_next;

    logic [MODE_BITS-1:0] mode_in;
    logic [MODE_BITS-1:0] merge_mode;
    logic                 run_covers;
    logic                 merge_ok;
    logic                 merge_new;
    logic                 merge_upg;
    logic                 tag_match;
    logic                 tag_is_cur;

    // Mode code three is taken as fast-and-slow.
    assign mode_in = (req.mode > MODE_FAST_AND_SLOW) ? MODE_FAST_AND_SLOW : req.mode;
    assign merge_mode = (req.cmd == CMD_ACTIVATE) ? MODE_FAST_AND_SLOW : mode_in;

    assign run_covers = run_vld_reg && (run_gen_reg == gen_cnt_reg)
                        && mode_covers(run_mode_reg, merge_mode);
    assign merge_new  = !run_covers && !pend_vld_reg;
    assign merge_upg  = !run_covers && pend_vld_reg && (pend_mode_reg == MODE_FAST)
                        && (merge_mode == MODE_FAST_AND_SLOW);
    assign merge_ok   = merge_new || merge_upg;

    // Compare at the wider of the two widths, zero-extended.
    assign tag_match  = 64'(run_gen_reg) == 64'(req.item_generation);
    assign tag_is_cur = 64'(gen_cnt_reg) == 64'(req.item_generation);

    always_comb
    begin
        stopped_next   = stopped_reg;
        accepting_next = accepting_reg;
        base_pend_next = base_pend_reg;
        run_vld_next   = run_vld_reg;
        run_mode_next  = run_mode_reg;
        run_gen_next   = run_gen_reg;
        pend_vld_next  = pend_vld_reg;
        pend_mode_next = pend_mode_reg;
        gen_cnt_next   = gen_cnt_reg;

        rsp = '0;

        case (req.cmd)
            CMD_ACTIVATE:
            begin
                if (!stopped_reg)
                begin
                    accepting_next = 1'b1;
                    if (!accepting_reg)
                    begin
                        base_pend_next = 1'b1;
                    end
                    if (merge_ok)
                    begin
                        pend_vld_next  = 1'b1;
                        pend_mode_next = merge_mode;
                    end
                    rsp.ok = merge_ok || !accepting_reg;
                end
            end
            CMD_REQUEST:
            begin
                if (!stopped_reg && accepting_reg)
                begin
                    if (merge_ok)
                    begin
                        pend_vld_next  = 1'b1;
                        pend_mode_next = merge_mode;
                    end
                    rsp.ok = merge_ok;
                end
            end
            CMD_PAUSE:
            begin
                if (!stopped_reg)
                begin
                    gen_cnt_next   = gen_cnt_reg + gen_t'(1);
                    accepting_next = 1'b0;
                    pend_vld_next  = 1'b0;
                    pend_mode_next = MODE_FAST;
                    base_pend_next = 1'b1;
                end
            end
            CMD_STOP:
            begin
                if (!stopped_reg)
                begin
                    gen_cnt_next   = gen_cnt_reg + gen_t'(1);
                    stopped_next   = 1'b1;
                    accepting_next = 1'b0;
                    base_pend_next = 1'b0;
                    pend_vld_next  = 1'b0;
                    pend_mode_next = MODE_FAST;
                end
            end
            CMD_TAKE_BASE:
            begin
                if (base_pend_reg)
                begin
                    base_pend_next = 1'b0;
                    rsp.ok         = 1'b1;
                end
            end
            CMD_TAKE_NEXT:
            begin
                if (!stopped_reg && accepting_reg && !base_pend_reg
                    && !run_vld_reg && pend_vld_reg)
                begin
                    run_vld_next   = 1'b1;
                    run_mode_next  = pend_mode_reg;
                    run_gen_next   = gen_cnt_reg;
                    pend_vld_next  = 1'b0;
                    pend_mode_next = MODE_FAST;
                    rsp.ok                 = 1'b1;
                    rsp.granted_valid      = 1'b1;
                    rsp.granted_mode       = pend_mode_reg;
                    rsp.granted_generation = TAG_BITS'(gen_cnt_reg);
                end
            end
            CMD_FINISH:
            begin
                run_vld_next  = 1'b0;
                run_mode_next = MODE_FAST;
                run_gen_next  = '0;
                rsp.ok = run_vld_reg && tag_match && (run_mode_reg == mode_in)
                         && !stopped_reg && accepting_reg && tag_is_cur;
            end
            default:
            begin
            end
        endcase

        // Status reflects the state after the command.
        rsp.has_action = stopped_next || base_pend_next || (!run_vld_next && pend_vld_next);
        rsp.busy_res   = base_pend_next || run_vld_next || pend_vld_next;
        rsp.is_stopped = stopped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg   <= 1'b0;
            accepting_reg <= 1'b0;
            base_pend_reg <= 1'b0;
            run_vld_reg   <= 1'b0;
            run_mode_reg  <= MODE_FAST;
            run_gen_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_mode_reg <= MODE_FAST;
            gen_cnt_reg   <= '0;
        end
        else if (step)
        begin
            stopped_reg   <= stopped_next;
            accepting_reg <= accepting_next;
            base_pend_reg <= base_pend_next;
            run_vld_reg   <= run_vld_next;
            run_mode_reg  <= run_mode_next;
            run_gen_reg   <= run_gen_next;
            pend_vld_reg  <= pend_vld_next;
            pend_mode_reg <= pend_mode_next;
            gen_cnt_reg   <= gen_cnt_next;
        end
    end

endmodule

// ===== hw/rtl/sample_request_coalescer.sv =====
// Sample request coalescer. Takes one command transaction per cycle on the
// req channel while req_stall is low and returns exactly one response
// transaction per command on the rsp channel, in order. A command sits in an
// input register, the coalescing state (stopped, accepting, baseline-pending,
// running job, pending mode, generation counter) is updated as it moves into
// the output register, which drives rsp_valid; the sustained rate is one
// transaction per cycle while rsp_stall stays low.
// A stalled response holds in the output register while the input register
// still takes one more command; req_stall rises only when both are full.
// Status fields in a response show the state after that command.
module sample_request_coalescer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  src_pkg::src_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output src_pkg::src_rsp_t rsp
);
    import src_pkg::*;

    src_req_t req_reg;
    logic     req_vld_reg, req_vld_next;
    src_rsp_t rsp_reg;
    logic     rsp_vld_reg, rsp_vld_next;
    src_rsp_t core_rsp;
    logic     advance;
    logic     req_take;

    // A command moves on when the output slot is free or being drained.
    assign advance  = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign req_vld_next = req_take || (req_vld_reg && !advance);
    assign rsp_vld_next = advance || (rsp_vld_reg && rsp_stall);

    src_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_reg),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/src_checker.sv =====
module src_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  src_pkg::src_rsp_t rsp
);
    import src_pkg::*;

    logic rsp_take;
    logic stop_seen_reg;

    assign rsp_take = rsp_valid && !rsp_stall;

    // Once a response reports stopped, every later one must too.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_seen_reg <= 1'b0;
        end
        else if (rsp_take && rsp.is_stopped)
        begin
            stop_seen_reg <= 1'b1;
        end
    end

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && stop_seen_reg |-> rsp.is_stopped)
        else $error("stopped status cleared");

    a_grant_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.granted_valid |->
            rsp.ok && rsp.busy_res && !rsp.has_action && !rsp.is_stopped)
        else $error("grant with inconsistent status");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.granted_valid |->
            rsp.granted_mode == MODE_FAST && rsp.granted_generation == '0)
        else $error("grant fields set without a grant");

    a_stop_action: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_stopped |-> rsp.has_action && !rsp.ok)
        else $error("stopped response with action clear or ok set");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind sample_request_coalescer src_checker u_src_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== tb/sv/tb_sample_request_coalescer.sv =====
module tb_sample_request_coalescer;

    timeunit 1ns;
    timeprecision 1ps;

    import src_pkg::*;

    // Command code the package leaves unnamed: the block must ignore it.
    localparam logic [CMD_BITS-1:0]  CMD_UNUSED = 3'd7;
    // Mode code three is read as fast and slow by every command.
    localparam logic [MODE_BITS-1:0] MODE_CODE_THREE = 2'd3;

    localparam int RANDOM_ITEMS = 900;
    localparam int BURST_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    src_req_t  req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    src_rsp_t  rsp;

    // Idle rates for the two sides, in percent; zero gives a stretch with
    // no gaps on that side.
    int unsigned idle_pct = 21;
    int unsigned stall_pct = 21;
    int unsigned mismatch_count = 0;

    // Responses owed by the block, oldest first.
    src_rsp_t rsp_due_q[$];

    // Predicted coalescer state.
    logic                 s_stopped;
    logic                 s_accepting;
    logic                 s_base_pend;
    logic                 s_run_valid;
    logic [MODE_BITS-1:0] s_run_mode;
    gen_t                 s_run_gen;
    logic                 s_pend_valid;
    logic [MODE_BITS-1:0] s_pend_mode;
    gen_t                 s_gen_count;

    sample_request_coalescer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Response side back-pressure, changed on the falling edge only.
    always @(negedge clk)
    begin
        rsp_stall = rst_n && (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    // Folds a wanted mode into the pending slot. Dropped when the running
    // job of the current generation already covers it; a pending fast is
    // upgraded when fast and slow is asked for.
    function automatic logic merge_request(logic [MODE_BITS-1:0] want);
        if (s_run_valid && s_run_gen == s_gen_count &&
            (s_run_mode == MODE_FAST_AND_SLOW || s_run_mode == want))
            return 1'b0;
        if (!s_pend_valid)
        begin
            s_pend_valid = 1'b1;
            s_pend_mode = want;
            return 1'b1;
        end
        if (s_pend_mode == MODE_FAST && want == MODE_FAST_AND_SLOW)
        begin
            s_pend_mode = MODE_FAST_AND_SLOW;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one command to the predicted state and returns the response.
    function automatic src_rsp_t coalesce_cmd(src_req_t item);
        logic [MODE_BITS-1:0] m;
        gen_t                 tag;
        logic                 changed;
        logic                 merged;
        logic                 match;
        src_rsp_t             r;

        r = '0;
        m = (item.mode > MODE_FAST_AND_SLOW) ? MODE_FAST_AND_SLOW : item.mode;
        tag = gen_t'(item.item_generation);
        case (item.cmd)
            CMD_ACTIVATE:
                if (!s_stopped)
                begin
                    changed = 1'b0;
                    if (!s_accepting)
                    begin
                        s_accepting = 1'b1;
                        s_base_pend = 1'b1;
                        changed = 1'b1;
                    end
                    merged = merge_request(MODE_FAST_AND_SLOW);
                    r.ok = merged | changed;
                end
            CMD_REQUEST:
                if (!s_stopped && s_accepting)
                    r.ok = merge_request(m);
            CMD_PAUSE:
                if (!s_stopped)
                begin
                    s_gen_count = s_gen_count + 1'b1;
                    s_accepting = 1'b0;
                    s_pend_valid = 1'b0;
                    s_pend_mode = '0;
                    s_base_pend = 1'b1;
                end
            CMD_STOP:
                if (!s_stopped)
                begin
                    s_gen_count = s_gen_count + 1'b1;
                    s_stopped = 1'b1;
                    s_accepting = 1'b0;
                    s_base_pend = 1'b0;
                    s_pend_valid = 1'b0;
                    s_pend_mode = '0;
                end
            CMD_TAKE_BASE:
                if (s_base_pend)
                begin
                    s_base_pend = 1'b0;
                    r.ok = 1'b1;
                end
            CMD_TAKE_NEXT:
                if (!s_stopped && s_accepting && !s_base_pend && !s_run_valid &&
                    s_pend_valid)
                begin
                    s_run_valid = 1'b1;
                    s_run_mode = s_pend_mode;
                    s_run_gen = s_gen_count;
                    s_pend_valid = 1'b0;
                    s_pend_mode = '0;
                    r.ok = 1'b1;
                    r.granted_valid = 1'b1;
                    r.granted_mode = s_run_mode;
                    r.granted_generation = TAG_BITS'(s_run_gen);
                end
            CMD_FINISH:
            begin
                // The running job is dropped whatever the outcome.
                match = s_run_valid && s_run_gen == tag && s_run_mode == m;
                s_run_valid = 1'b0;
                s_run_mode = '0;
                s_run_gen = '0;
                r.ok = match && !s_stopped && s_accepting && tag == s_gen_count;
            end
            default:
                ;
        endcase
        r.has_action = s_stopped || s_base_pend || (!s_run_valid && s_pend_valid);
        r.busy_res = s_base_pend || s_run_valid || s_pend_valid;
        r.is_stopped = s_stopped;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Driving and checking
    //------------------------------------------------------------------

    function automatic src_req_t cmd_item(logic [CMD_BITS-1:0] c,
                                          logic [MODE_BITS-1:0] m,
                                          logic [TAG_BITS-1:0] g);
        src_req_t item;
        item.cmd = c;
        item.mode = m;
        item.item_generation = g;
        return item;
    endfunction

    // Sends one command transaction. Called and returns at a falling edge;
    // valid is left high so back-to-back commands need no gap.
    task automatic send_cmd(src_req_t item);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        rsp_due_q.push_back(coalesce_cmd(item));
        @(negedge clk);
    endtask

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Every accepted response is held against the oldest prediction.
    always @(posedge clk)
    begin
        src_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due_q.size() == 0)
                report_mismatch("unexpected transaction", 16'h0, 16'h0);
            else
            begin
                want = rsp_due_q.pop_front();
                if (rsp.ok !== want.ok)
                    report_mismatch("ok", 16'(rsp.ok), 16'(want.ok));
                if (rsp.granted_valid !== want.granted_valid)
                    report_mismatch("granted_valid", 16'(rsp.granted_valid),
                                    16'(want.granted_valid));
                if (rsp.granted_mode !== want.granted_mode)
                    report_mismatch("granted_mode", 16'(rsp.granted_mode),
                                    16'(want.granted_mode));
                if (rsp.granted_generation !== want.granted_generation)
                    report_mismatch("granted_generation", rsp.granted_generation,
                                    want.granted_generation);
                if (rsp.has_action !== want.has_action)
                    report_mismatch("has_action", 16'(rsp.has_action), 16'(want.has_action));
                if (rsp.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 16'(rsp.busy_res), 16'(want.busy_res));
                if (rsp.is_stopped !== want.is_stopped)
                    report_mismatch("is_stopped", 16'(rsp.is_stopped), 16'(want.is_stopped));
            end
        end
    end

    // Random command, biased towards well-formed job flow: finishes mostly
    // name the running job, stop only when allowed since it is permanent.
    function automatic src_req_t random_cmd(bit allow_stop);
        src_req_t    item;
        int unsigned pick;

        item = cmd_item(CMD_UNUSED, MODE_BITS'($urandom_range(3)),
                        TAG_BITS'($urandom_range(16'hFFFF)));
        pick = $urandom_range(99);
        if (pick < 30)
            item.cmd = CMD_REQUEST;
        else if (pick < 50)
            item.cmd = CMD_TAKE_NEXT;
        else if (pick < 70)
        begin
            item.cmd = CMD_FINISH;
            if (s_run_valid && $urandom_range(3) != 0)
            begin
                item.item_generation = TAG_BITS'(s_run_gen);
                item.mode = (s_run_mode == MODE_FAST_AND_SLOW && $urandom_range(1))
                            ? MODE_CODE_THREE : s_run_mode;
            end
        end
        else if (pick < 80)
            item.cmd = CMD_TAKE_BASE;
        else if (pick < 89)
            item.cmd = CMD_ACTIVATE;
        else if (pick < 95)
            item.cmd = CMD_PAUSE;
        else if (pick < 97 && allow_stop)
            item.cmd = CMD_STOP;
        return item;
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Walks through each command but stop, the coalescing rules and the corner cases
    // that do not need a stop.
    task automatic test_directed_sequence();
        send_cmd(cmd_item(CMD_REQUEST,   MODE_FAST,          16'h0000)); // not accepting yet
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_BASE, MODE_FAST,          16'h0000)); // nothing to take
        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST,          16'h0000)); // no job running
        send_cmd(cmd_item(CMD_ACTIVATE,  MODE_SLOW,          16'h0000));
        send_cmd(cmd_item(CMD_ACTIVATE,  MODE_FAST,          16'h0000)); // already active
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000)); // baseline blocks
        send_cmd(cmd_item(CMD_TAKE_BASE, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000)); // grant fast+slow
        send_cmd(cmd_item(CMD_REQUEST,   MODE_SLOW,          16'h0000)); // covered, dropped
        send_cmd(cmd_item(CMD_FINISH,    MODE_CODE_THREE,    16'h0000)); // code three = f+s
        send_cmd(cmd_item(CMD_REQUEST,   MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_REQUEST,   MODE_CODE_THREE,    16'h0000)); // upgrade pending
        send_cmd(cmd_item(CMD_REQUEST,   MODE_SLOW,          16'h0000)); // slot taken
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_SLOW,          16'h0000));
        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST,          16'h0000)); // wrong mode
        send_cmd(cmd_item(CMD_REQUEST,   MODE_SLOW,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_PAUSE,     MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_REQUEST,   MODE_FAST_AND_SLOW, 16'h0000)); // paused
        send_cmd(cmd_item(CMD_ACTIVATE,  MODE_FAST,          16'h0000)); // old job not covering
        send_cmd(cmd_item(CMD_FINISH,    MODE_SLOW,          16'h0000)); // stale generation
        send_cmd(cmd_item(CMD_UNUSED,    MODE_CODE_THREE,    16'hFFFF));
        send_cmd(cmd_item(CMD_TAKE_BASE, MODE_FAST,          16'hFFFF));
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'hFFFF));
    endtask

    // Grants and finishes a job, then a long run of commands with no gaps
    // on either side.
    task automatic test_back_to_back();
        idle_pct = 0;
        stall_pct = 0;
        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_PAUSE,     MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_ACTIVATE,  MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_BASE, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST_AND_SLOW, TAG_BITS'(s_gen_count)));
        repeat (BURST_ITEMS)
            send_cmd(random_cmd(1'b0));
        idle_pct = 21;
        stall_pct = 21;
    endtask

    // Random job traffic without stop; the unused code does not count.
    task automatic test_random_traffic();
        src_req_t item;
        int       sent;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            item = random_cmd(1'b0);
            send_cmd(item);
            if (item.cmd != CMD_UNUSED)
                sent++;
        end
    endtask

    // Stop with a job running, finish it afterwards, then random commands
    // against the stopped block.
    task automatic test_stop_behaviour();
        gen_t job_gen;

        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_PAUSE,     MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_ACTIVATE,  MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_BASE, MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_TAKE_NEXT, MODE_FAST,          16'h0000));
        job_gen = s_run_gen;
        send_cmd(cmd_item(CMD_REQUEST,   MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_STOP,      MODE_FAST,          16'h0000));
        send_cmd(cmd_item(CMD_FINISH,    MODE_FAST_AND_SLOW, TAG_BITS'(job_gen)));
        send_cmd(cmd_item(CMD_STOP,      MODE_SLOW,          16'h0000));
        repeat (40)
            send_cmd(random_cmd(1'b1));
    endtask

    //------------------------------------------------------------------
    // Run
    //------------------------------------------------------------------

    initial
    begin
        s_stopped = 1'b0;
        s_accepting = 1'b0;
        s_base_pend = 1'b0;
        s_run_valid = 1'b0;
        s_run_mode = '0;
        s_run_gen = '0;
        s_pend_valid = 1'b0;
        s_pend_mode = '0;
        s_gen_count = '0;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_sequence();
        test_back_to_back();
        test_random_traffic();
        test_stop_behaviour();

        req_valid = 1'b0;
        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
